>>> src/cau_pkg.sv
// Package for the complex arithmetic unit: operation classes, status codes,
// back-end sequencer states and the control struct passed from front to back.
// No dependencies.
package cau_pkg;

	// Opcodes as they arrive on the opcode port
	localparam logic [2:0] OPC_ADD = 3'd0;
	localparam logic [2:0] OPC_SUB = 3'd1;
	localparam logic [2:0] OPC_MUL = 3'd2;
	localparam logic [2:0] OPC_DIV = 3'd3;
	localparam logic [2:0] OPC_CMP = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef enum logic [2:0] {
		CLS_ADD,
		CLS_SUB,
		CLS_MUL,
		CLS_DIV,
		CLS_CMP,
		CLS_NOP
	} op_class_t;

	typedef struct packed {
		op_class_t cls;
		logic      div_zero;
	} item_ctrl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PROD,
		BK_SUMS,
		BK_DIV
	} back_state_t;

endpackage

>>> src/cau_front.sv
// Front end: accepts items, classifies the opcode, flags a zero divisor and
// queues the item for the back end. Depends on cau_pkg.
module cau_front #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           opcode,
	input  logic signed [W-1:0]  lhs_real,
	input  logic signed [W-1:0]  lhs_imag,
	input  logic signed [W-1:0]  rhs_real,
	input  logic signed [W-1:0]  rhs_imag,
	input  logic                 pop,
	output logic                 head_valid,
	output cau_pkg::item_ctrl_t  head_ctrl,
	output logic signed [W-1:0]  head_a,
	output logic signed [W-1:0]  head_b,
	output logic signed [W-1:0]  head_c,
	output logic signed [W-1:0]  head_d
);
	import cau_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	item_ctrl_t             ctrl_q [DEPTH];
	logic signed [W-1:0]    a_q [DEPTH];
	logic signed [W-1:0]    b_q [DEPTH];
	logic signed [W-1:0]    c_q [DEPTH];
	logic signed [W-1:0]    d_q [DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [PW:0]            count_q;
	item_ctrl_t             in_ctrl;
	logic                   push;
	logic                   do_pop;

	// Classify the incoming item
	always_comb begin
		case (opcode)
			OPC_ADD: in_ctrl.cls = CLS_ADD;
			OPC_SUB: in_ctrl.cls = CLS_SUB;
			OPC_MUL: in_ctrl.cls = CLS_MUL;
			OPC_DIV: in_ctrl.cls = CLS_DIV;
			OPC_CMP: in_ctrl.cls = CLS_CMP;
			default: in_ctrl.cls = CLS_NOP;
		endcase
		in_ctrl.div_zero = (rhs_real == '0) && (rhs_imag == '0);
	end

	assign busy       = (count_q == (PW+1)'(DEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_ptr_q] <= in_ctrl;
			a_q[wr_ptr_q]    <= lhs_real;
			b_q[wr_ptr_q]    <= lhs_imag;
			c_q[wr_ptr_q]    <= rhs_real;
			d_q[wr_ptr_q]    <= rhs_imag;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !do_pop)
				count_q <= count_q + (PW+1)'(1);
			else if (do_pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	assign head_ctrl = ctrl_q[rd_ptr_q];
	assign head_a    = a_q[rd_ptr_q];
	assign head_b    = b_q[rd_ptr_q];
	assign head_c    = c_q[rd_ptr_q];
	assign head_d    = d_q[rd_ptr_q];

endmodule

>>> src/cau_div.sv
// Restoring divider, one quotient bit a cycle, two lanes sharing a divisor.
// Forms (mag << F) / den for the real and imaginary parts. Depends on cau_pkg.
module cau_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [2*W:0]           mag_r,
	input  logic [2*W:0]           mag_i,
	input  logic [2*W-1:0]         den,
	output logic                   done,
	output logic [2*W+F:0]         quo_r,
	output logic [2*W+F:0]         quo_i
);
	import cau_pkg::*;

	localparam int MW = 2*W + 1;
	localparam int QW = MW + F;
	localparam int RW = 2*W + 1;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0]  num_q [2];
	logic [QW-1:0]  quo_q [2];
	logic [RW-1:0]  rem_q [2];
	logic [2*W-1:0] den_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic           done_q;
	logic [RW-1:0]  sh   [2];
	logic           ge   [2];

	// One restoring step per lane
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sh[l] = {rem_q[l][RW-2:0], num_q[l][QW-1]};
			ge[l] = (sh[l] >= {1'b0, den_q});
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (go) begin
			num_q[0] <= QW'(mag_r) << F;
			num_q[1] <= QW'(mag_i) << F;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			den_q    <= den;
		end else if (run_q) begin
			for (int l = 0; l < 2; l++) begin
				num_q[l] <= {num_q[l][QW-2:0], 1'b0};
				rem_q[l] <= ge[l] ? (sh[l] - {1'b0, den_q}) : sh[l];
				quo_q[l] <= {quo_q[l][QW-2:0], ge[l]};
			end
		end
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign quo_r = quo_q[0];
	assign quo_i = quo_q[1];

endmodule

>>> src/cau_back.sv
// Back end: takes queued items one at a time, forms products and sums,
// runs the divider, saturates and drives the result strobe.
// Depends on cau_pkg and cau_div.
module cau_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  cau_pkg::item_ctrl_t  head_ctrl,
	input  logic signed [W-1:0]  head_a,
	input  logic signed [W-1:0]  head_b,
	input  logic signed [W-1:0]  head_c,
	input  logic signed [W-1:0]  head_d,
	output logic                 pop,
	output logic                 done,
	output logic signed [W-1:0]  res_real,
	output logic signed [W-1:0]  res_imag,
	output logic                 is_equal,
	output logic [1:0]           status
);
	import cau_pkg::*;

	localparam int PW = 2*W;
	localparam int MW = 2*W + 1;
	localparam int QW = MW + F;
	localparam logic [MW-1:0] FMASK = (MW'(1) << F) - MW'(1);

	back_state_t            st_q, st_n;
	item_ctrl_t             ctrl_q;
	logic signed [W-1:0]    a_q, b_q, c_q, d_q;
	logic signed [PW-1:0]   pac_q, pbd_q, pad_q, pbc_q, pcc_q, pdd_q;
	logic signed [W:0]      sum_r_q, sum_i_q;
	logic                   neg_r_q, neg_i_q;
	logic signed [W-1:0]    res_real_q, res_imag_q;
	logic                   eq_q, done_q;
	logic [1:0]             status_q;

	logic signed [MW-1:0]   num_r, num_i;
	logic                   neg_r, neg_i;
	logic [MW-1:0]          mag_r, mag_i;
	logic [MW-1:0]          fq_r, fq_i;
	logic [PW-1:0]          den;
	logic                   as_neg_r, as_neg_i;
	logic [W:0]             as_mag_r, as_mag_i;
	logic [W:0]             cl_r, cl_i;
	logic                   div_go, div_done;
	logic [QW-1:0]          quo_r, quo_i;
	logic                   load_sums, load_div;

	// Clamp sign and magnitude to the W-bit range; top bit flags saturation
	function automatic logic [W:0] clampf(input logic neg, input logic [QW-1:0] mag);
		logic [QW-1:0] lim;
		logic [W:0]    r;
		begin
			lim = QW'(1) << (W-1);
			if (neg) begin
				if (mag > lim)
					r = {1'b1, 1'b1, {(W-1){1'b0}}};
				else
					r = {1'b0, W'(-mag)};
			end else begin
				if (mag > lim - QW'(1))
					r = {1'b1, 1'b0, {(W-1){1'b1}}};
				else
					r = {1'b0, W'(mag)};
			end
			return r;
		end
	endfunction

	// Next state
	always_comb begin
		case (st_q)
			BK_IDLE: st_n = head_valid ? BK_PROD : BK_IDLE;
			BK_PROD: st_n = BK_SUMS;
			BK_SUMS: st_n = (ctrl_q.cls == CLS_DIV && !ctrl_q.div_zero) ? BK_DIV : BK_IDLE;
			BK_DIV:  st_n = div_done ? BK_IDLE : BK_DIV;
			default: st_n = BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pop       = (st_q == BK_IDLE) && head_valid;
		div_go    = (st_q == BK_SUMS) && (ctrl_q.cls == CLS_DIV) && !ctrl_q.div_zero;
		load_sums = (st_q == BK_SUMS) && !div_go;
		load_div  = (st_q == BK_DIV) && div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= BK_IDLE;
		else
			st_q <= st_n;
	end

	// Item latch and products
	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_q <= head_ctrl;
			a_q    <= head_a;
			b_q    <= head_b;
			c_q    <= head_c;
			d_q    <= head_d;
		end
		if (st_q == BK_PROD) begin
			pac_q <= a_q * c_q;
			pbd_q <= b_q * d_q;
			pad_q <= a_q * d_q;
			pbc_q <= b_q * c_q;
			pcc_q <= c_q * c_q;
			pdd_q <= d_q * d_q;
			if (ctrl_q.cls == CLS_SUB) begin
				sum_r_q <= (W+1)'(a_q) - (W+1)'(c_q);
				sum_i_q <= (W+1)'(b_q) - (W+1)'(d_q);
			end else begin
				sum_r_q <= (W+1)'(a_q) + (W+1)'(c_q);
				sum_i_q <= (W+1)'(b_q) + (W+1)'(d_q);
			end
		end
		if (div_go) begin
			neg_r_q <= neg_r;
			neg_i_q <= neg_i;
		end
	end

	// Exact numerators and divisor
	always_comb begin
		if (ctrl_q.cls == CLS_DIV) begin
			num_r = MW'(pac_q) + MW'(pbd_q);
			num_i = MW'(pbc_q) - MW'(pad_q);
		end else begin
			num_r = MW'(pac_q) - MW'(pbd_q);
			num_i = MW'(pad_q) + MW'(pbc_q);
		end
		neg_r = num_r[MW-1];
		neg_i = num_i[MW-1];
		mag_r = neg_r ? MW'(-num_r) : MW'(num_r);
		mag_i = neg_i ? MW'(-num_i) : MW'(num_i);
		den   = PW'(pcc_q) + PW'(pdd_q);
		// floor shift of the products
		fq_r  = (mag_r >> F) + MW'(neg_r && ((mag_r & FMASK) != '0));
		fq_i  = (mag_i >> F) + MW'(neg_i && ((mag_i & FMASK) != '0));
		// sign and magnitude of the sums
		as_neg_r = sum_r_q[W];
		as_neg_i = sum_i_q[W];
		as_mag_r = as_neg_r ? (W+1)'(-sum_r_q) : (W+1)'(sum_r_q);
		as_mag_i = as_neg_i ? (W+1)'(-sum_i_q) : (W+1)'(sum_i_q);
		case (ctrl_q.cls)
			CLS_ADD, CLS_SUB: begin
				cl_r = clampf(as_neg_r, QW'(as_mag_r));
				cl_i = clampf(as_neg_i, QW'(as_mag_i));
			end
			CLS_MUL: begin
				cl_r = clampf(neg_r, QW'(fq_r));
				cl_i = clampf(neg_i, QW'(fq_i));
			end
			CLS_DIV: begin
				// a zero divisor gives a zero result
				if (ctrl_q.div_zero) begin
					cl_r = '0;
					cl_i = '0;
				end else begin
					cl_r = clampf(neg_r_q, quo_r);
					cl_i = clampf(neg_i_q, quo_i);
				end
			end
			default: begin
				cl_r = '0;
				cl_i = '0;
			end
		endcase
	end

	cau_div #(
		.W(W),
		.F(F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.mag_r  (mag_r),
		.mag_i  (mag_i),
		.den    (den),
		.done   (div_done),
		.quo_r  (quo_r),
		.quo_i  (quo_i)
	);

	// Result registers
	always_ff @(posedge clk) begin
		if (load_sums || load_div) begin
			res_real_q <= cl_r[W-1:0];
			res_imag_q <= cl_i[W-1:0];
			eq_q       <= (ctrl_q.cls == CLS_CMP) && (a_q == c_q) && (b_q == d_q);
			if (ctrl_q.cls == CLS_DIV && ctrl_q.div_zero)
				status_q <= ST_DIV0;
			else if (cl_r[W] || cl_i[W])
				status_q <= ST_SAT;
			else
				status_q <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= load_sums || load_div;
	end

	assign done     = done_q;
	assign res_real = res_real_q;
	assign res_imag = res_imag_q;
	assign is_equal = eq_q;
	assign status   = status_q;

endmodule

>>> src/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end with item queue and
// back end with products, divider and saturation. Depends on cau_pkg,
// cau_front and cau_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | start, busy        | opcode, lhs_real, lhs_imag, rhs_real, rhs_imag
//  result   | done (one cycle)   | res_real, res_imag, is_equal, status
//
// Add, subtract, compare and multiply pass through the back-end states BK_PROD and
// BK_SUMS; a divide by a non-zero divisor also waits in BK_DIV for the bit-serial divider.
// The back end works one item at a time; a four-deep queue keeps accepting
// while it works, and busy is high only when the queue is full.
// Reset clears the queue, sequencer and strobe. The receiver cannot stall.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    opcode,
	input  logic signed [DATA_WIDTH-1:0]  lhs_real,
	input  logic signed [DATA_WIDTH-1:0]  lhs_imag,
	input  logic signed [DATA_WIDTH-1:0]  rhs_real,
	input  logic signed [DATA_WIDTH-1:0]  rhs_imag,
	output logic                          done,
	output logic signed [DATA_WIDTH-1:0]  res_real,
	output logic signed [DATA_WIDTH-1:0]  res_imag,
	output logic                          is_equal,
	output logic [1:0]                    status
);
	import cau_pkg::*;

	logic                          pop;
	logic                          head_valid;
	item_ctrl_t                    head_ctrl;
	logic signed [DATA_WIDTH-1:0]  head_a, head_b, head_c, head_d;

	cau_front #(
		.W(DATA_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.lhs_real   (lhs_real),
		.lhs_imag   (lhs_imag),
		.rhs_real   (rhs_real),
		.rhs_imag   (rhs_imag),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ctrl  (head_ctrl),
		.head_a     (head_a),
		.head_b     (head_b),
		.head_c     (head_c),
		.head_d     (head_d)
	);

	cau_back #(
		.W(DATA_WIDTH),
		.F(FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ctrl  (head_ctrl),
		.head_a     (head_a),
		.head_b     (head_b),
		.head_c     (head_c),
		.head_d     (head_d),
		.pop        (pop),
		.done       (done),
		.res_real   (res_real),
		.res_imag   (res_imag),
		.is_equal   (is_equal),
		.status     (status)
	);

`ifndef SYNTH
	// The result strobe is never high in consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe in consecutive cycles");

	// A zero divisor gives a zero result
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DIV0) |-> (res_real == '0 && res_imag == '0))
		else $error("divide by zero with non-zero result");

	// Equality is only reported with ok status
	a_eq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_equal) |-> (status == ST_OK))
		else $error("equality flag with bad status");
`endif

endmodule
